@@ sv/lss_pkg.sv @@
// Shared constants for the LIFO stack with search.
// Holds operation and status codes and the default stack depth; no dependencies.
package lss_pkg;

   localparam int LSS_DEPTH = 64;

   localparam int DATA_W   = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
   localparam logic [OP_W-1:0] OP_POP    = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
   localparam logic [OP_W-1:0] OP_DUMP   = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

endpackage

@@ sv/lifo_stack_with_search_top.sv @@
// LIFO stack of signed 32-bit words with push, pop, search and dump.
// Depends on lss_pkg and lss_ram (entry storage).
//
//   channel | direction | ports
//   req     | in        | req_valid, req_ready, req_op, req_value
//   rsp     | out       | rsp_valid, rsp_ready, rsp_data, rsp_status, rsp_found,
//           |           | rsp_last, rsp_count
//
// Push and any operation on an empty stack answer directly; pop makes one RAM
// read; search and dump both walk the entry RAM one read per cycle while the
// result port takes items, top to base, and search stops at the first hit.
// Reset clears the state, the fill count and the result valid; entries need no clearing pass.
// A stalled result port holds the walk; the RAM read data waits in place.
module lifo_stack_with_search_top
   import lss_pkg::*;
#(
   parameter int DEPTH = LSS_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [OP_W-1:0]            req_op,
   input  logic signed [DATA_W-1:0]   req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [DATA_W-1:0]   rsp_data,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_found,
   output logic                       rsp_last,
   output logic [COUNT_W-1:0]         rsp_count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_POP    = 2'd1;
   localparam logic [1:0] ST_SEARCH = 2'd2;
   localparam logic [1:0] ST_DUMP   = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [CW-1:0]             fill_ff, fill_in;
   logic [AW-1:0]             rd_idx_ff, rd_idx_in;
   logic signed [DATA_W-1:0]  value_ff, value_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;

   logic                      rsp_load;
   logic [CW+COUNT_W-1:0]     fill_ext;

   logic                      ram_we, ram_re;
   logic [AW-1:0]             ram_waddr, ram_raddr;
   logic [DATA_W-1:0]         ram_rdata;

   logic accept, slot_free, is_full, is_empty;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign is_full   = (fill_ff == CW'(DEPTH));
   assign is_empty  = (fill_ff == '0);

   lss_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_value),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      rd_idx_in     = rd_idx_ff;
      value_in      = value_ff;
      rsp_load      = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_last_in   = rsp_last_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_waddr     = fill_ff[AW-1:0];
      ram_raddr     = rd_idx_ff - AW'(1);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in  = req_value;
               ram_raddr = AW'(fill_ff - CW'(1));
               rd_idx_in = AW'(fill_ff - CW'(1));
               unique case (req_op) inside
                  OP_PUSH: begin
                     rsp_load      = 1'b1;
                     rsp_data_in   = '0;
                     rsp_found_in  = 1'b0;
                     rsp_last_in   = 1'b1;
                     if (is_full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        rsp_status_in = STAT_OK;
                        ram_we        = 1'b1;
                        fill_in       = fill_ff + CW'(1);
                     end
                  end
                  OP_POP, OP_SEARCH, OP_DUMP: begin
                     if (is_empty) begin
                        rsp_load      = 1'b1;
                        rsp_data_in   = '0;
                        rsp_status_in = STAT_EMPTY;
                        rsp_found_in  = 1'b0;
                        rsp_last_in   = 1'b1;
                     end else begin
                        ram_re = 1'b1;
                        if (req_op == OP_POP) begin
                           fill_in  = fill_ff - CW'(1);
                           state_in = ST_POP;
                        end else if (req_op == OP_SEARCH) begin
                           state_in = ST_SEARCH;
                        end else begin
                           state_in = ST_DUMP;
                        end
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_POP: begin
            if (slot_free) begin
               rsp_load      = 1'b1;
               rsp_data_in   = ram_rdata;
               rsp_status_in = STAT_OK;
               rsp_found_in  = 1'b0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            if (slot_free) begin
               if (ram_rdata == value_ff) begin
                  rsp_load      = 1'b1;
                  rsp_data_in   = value_ff;
                  rsp_status_in = STAT_OK;
                  rsp_found_in  = 1'b1;
                  rsp_last_in   = 1'b1;
                  state_in      = ST_IDLE;
               end else if (rd_idx_ff == '0) begin
                  rsp_load      = 1'b1;
                  rsp_data_in   = '0;
                  rsp_status_in = STAT_OK;
                  rsp_found_in  = 1'b0;
                  rsp_last_in   = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  // advance toward the base
                  ram_re    = 1'b1;
                  rd_idx_in = rd_idx_ff - AW'(1);
               end
            end
         end
         ST_DUMP: begin
            if (slot_free) begin
               rsp_load      = 1'b1;
               rsp_data_in   = ram_rdata;
               rsp_status_in = STAT_OK;
               rsp_found_in  = 1'b0;
               rsp_last_in   = (rd_idx_ff == '0);
               if (rd_idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  ram_re    = 1'b1;
                  rd_idx_in = rd_idx_ff - AW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // count reports the fill after the operation, wrapped to the port width
   assign fill_ext     = {{COUNT_W{1'b0}}, fill_in};
   assign rsp_count_in = rsp_load ? fill_ext[COUNT_W-1:0] : rsp_count_ff;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      value_ff      <= value_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_count  = rsp_count_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill count exceeds stack depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_PUSH && !is_full) |=> fill_ff == $past(fill_ff) + CW'(1))
      else $error("push did not grow the stack by one");

   a_walk_keeps_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH || state_ff == ST_DUMP) |=> $stable(fill_ff))
      else $error("fill count changed during a walk");

   a_partial_only_dump: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> state_ff == ST_DUMP)
      else $error("non-final item outside a dump");

   a_found_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> rsp_data_ff == value_ff)
      else $error("search hit reports the wrong word");

endmodule

@@ sv/lss_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data updates only on a read enable and holds otherwise. No dependencies.
module lss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ verif/lss_stack_checker.sv @@
// Checker for the LIFO stack with search: watches the req and rsp channels,
// keeps a shadow stack to predict every result item and compares field by field.
// Depends on lss_pkg.
module lss_stack_checker
   import lss_pkg::*;
#(
   parameter int DEPTH = LSS_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [OP_W-1:0]           req_op,
   input  logic signed [DATA_W-1:0]  req_value,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [DATA_W-1:0]  rsp_data,
   input  logic [STATUS_W-1:0]       rsp_status,
   input  logic                      rsp_found,
   input  logic                      rsp_last,
   input  logic [COUNT_W-1:0]        rsp_count,
   output int                        mismatches,
   output int                        outstanding
);

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [STATUS_W-1:0]      status;
      logic                     found;
      logic                     last;
      logic [COUNT_W-1:0]       count;
   } stack_rsp_type;

   logic signed [DATA_W-1:0] shadow_entries [DEPTH];
   int                       shadow_fill;
   stack_rsp_type            pending_rsps [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
      shadow_fill = 0;
   end

   task automatic report_mismatch(string msg);
      $display("%0t: stack rsp mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   // count is taken after the operation has updated the shadow fill
   task automatic queue_rsp(logic signed [DATA_W-1:0] data, logic [STATUS_W-1:0] status,
                            logic found, logic last);
      stack_rsp_type r;
      r.data   = data;
      r.status = status;
      r.found  = found;
      r.last   = last;
      r.count  = COUNT_W'(shadow_fill);
      pending_rsps.push_back(r);
   endtask

   task automatic apply_stack_op(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value);
      logic hit;
      hit = 1'b0;
      case (op)
         OP_PUSH: begin
            if (shadow_fill >= DEPTH) begin
               queue_rsp('0, STAT_FULL, 1'b0, 1'b1);
            end else begin
               shadow_entries[shadow_fill] = value;
               shadow_fill++;
               queue_rsp('0, STAT_OK, 1'b0, 1'b1);
            end
         end
         OP_POP: begin
            if (shadow_fill == 0) begin
               queue_rsp('0, STAT_EMPTY, 1'b0, 1'b1);
            end else begin
               shadow_fill--;
               queue_rsp(shadow_entries[shadow_fill], STAT_OK, 1'b0, 1'b1);
            end
         end
         OP_SEARCH: begin
            if (shadow_fill == 0) begin
               queue_rsp('0, STAT_EMPTY, 1'b0, 1'b1);
            end else begin
               for (int i = 0; i < shadow_fill; i++) begin
                  if (shadow_entries[i] == value) hit = 1'b1;
               end
               queue_rsp(hit ? value : '0, STAT_OK, hit, 1'b1);
            end
         end
         default: begin
            // dump: top to base, last marks the base entry
            if (shadow_fill == 0) begin
               queue_rsp('0, STAT_EMPTY, 1'b0, 1'b1);
            end else begin
               for (int i = shadow_fill - 1; i >= 0; i--) begin
                  queue_rsp(shadow_entries[i], STAT_OK, 1'b0, i == 0);
               end
            end
         end
      endcase
   endtask

   task automatic check_rsp();
      stack_rsp_type want;
      if (pending_rsps.size() == 0) begin
         report_mismatch($sformatf("unexpected item data=%0d status=%0d", rsp_data, rsp_status));
         return;
      end
      want = pending_rsps.pop_front();
      if (rsp_data !== want.data)
         report_mismatch($sformatf("data got %0d want %0d", rsp_data, want.data));
      if (rsp_status !== want.status)
         report_mismatch($sformatf("status got %0d want %0d", rsp_status, want.status));
      if (rsp_found !== want.found)
         report_mismatch($sformatf("found got %0b want %0b", rsp_found, want.found));
      if (rsp_last !== want.last)
         report_mismatch($sformatf("last got %0b want %0b", rsp_last, want.last));
      if (rsp_count !== want.count)
         report_mismatch($sformatf("count got %0d want %0d", rsp_count, want.count));
   endtask

   // predict first so a same-edge result still finds its expectation
   always @(posedge clock) begin
      if (reset) begin
         shadow_fill = 0;
         pending_rsps.delete();
      end else begin
         if (req_valid && req_ready) apply_stack_op(req_op, req_value);
         if (rsp_valid && rsp_ready) check_rsp();
      end
      outstanding <= pending_rsps.size();
   end

endmodule

@@ verif/tb_lifo_stack_with_search_top.sv @@
// Testbench top for the LIFO stack with search: drives req items and rsp stalls,
// gives the verdict. Depends on lss_pkg, lss_stack_checker and the block's RTL.
module tb_lifo_stack_with_search_top
   import lss_pkg::*;
();

   localparam int DEPTH = LSS_DEPTH;

   typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} shape_type;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [OP_W-1:0]           req_op    = OP_PUSH;
   logic signed [DATA_W-1:0]  req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [DATA_W-1:0]  rsp_data;
   logic [STATUS_W-1:0]       rsp_status;
   logic                      rsp_found;
   logic                      rsp_last;
   logic [COUNT_W-1:0]        rsp_count;

   int mismatches;
   int outstanding;
   int send_idle_pct = 18;
   int recv_idle_pct = 73;
   int stack_level   = 0;

   lifo_stack_with_search_top #(.DEPTH(DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .rsp_status (rsp_status),
      .rsp_found  (rsp_found),
      .rsp_last   (rsp_last),
      .rsp_count  (rsp_count)
   );

   lss_stack_checker #(.DEPTH(DEPTH)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_op      (req_op),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .rsp_status  (rsp_status),
      .rsp_found   (rsp_found),
      .rsp_last    (rsp_last),
      .rsp_count   (rsp_count),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // acceptance leaves valid high; the next item or a pause decides what follows
   task automatic send_item(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (op)
         OP_PUSH: if (stack_level < DEPTH) stack_level++;
         OP_POP:  if (stack_level > 0) stack_level--;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return {1'b1, {(DATA_W-1){1'b0}}};
         1:       return {1'b0, {(DATA_W-1){1'b1}}};
         // small pool around zero so searches hit often
         2, 3, 4: return $signed($urandom_range(15)) - 8;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_op(shape_type mode);
      int r;
      r = $urandom_range(99);
      case (mode)
         MODE_FILL:
            return (r < 85) ? OP_PUSH : (r < 90) ? OP_POP : (r < 96) ? OP_SEARCH : OP_DUMP;
         MODE_DRAIN:
            return (r < 10) ? OP_PUSH : (r < 85) ? OP_POP : (r < 95) ? OP_SEARCH : OP_DUMP;
         default:
            return (r < 35) ? OP_PUSH : (r < 60) ? OP_POP : (r < 88) ? OP_SEARCH : OP_DUMP;
      endcase
   endfunction

   task automatic run_phase(int n_items, shape_type first_mode);
      shape_type mode;
      int        seg_left;
      int        sent;
      mode     = first_mode;
      seg_left = 0;
      sent     = 0;
      while (sent < n_items) begin
         if (seg_left == 0) begin
            mode     = (sent == 0) ? first_mode : shape_type'($urandom_range(2));
            seg_left = (mode == MODE_MIX) ? 16 : 150;
         end
         // push a few past full or pop a few past empty, then move on
         if (mode == MODE_FILL && stack_level == DEPTH && seg_left > 4) seg_left = 4;
         if (mode == MODE_DRAIN && stack_level == 0 && seg_left > 4) seg_left = 4;
         send_item(pick_op(mode), pick_value());
         seg_left--;
         sent++;
         if ($urandom_range(39) == 0) wait_drained();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty stack cases
      send_item(OP_DUMP, '0);
      send_item(OP_POP, '0);
      send_item(OP_SEARCH, '0);
      // extremes of the value
      send_item(OP_PUSH, {1'b1, {(DATA_W-1){1'b0}}});
      send_item(OP_PUSH, {1'b0, {(DATA_W-1){1'b1}}});
      send_item(OP_PUSH, '0);
      send_item(OP_PUSH, '1);
      send_item(OP_PUSH, 1);
      // hit at base, hit at top, miss, hit in the middle
      send_item(OP_SEARCH, {1'b1, {(DATA_W-1){1'b0}}});
      send_item(OP_SEARCH, 1);
      send_item(OP_SEARCH, 12345);
      send_item(OP_SEARCH, {1'b0, {(DATA_W-1){1'b1}}});
      send_item(OP_DUMP, '0);
      send_item(OP_POP, '0);
      send_item(OP_POP, '0);
      send_item(OP_DUMP, '0);
      send_item(OP_POP, '0);
      send_item(OP_POP, '0);
      send_item(OP_POP, '0);
      send_item(OP_POP, '0);
      send_item(OP_PUSH, 32'h5a5a_5a5a);
      send_item(OP_DUMP, '0);
      send_item(OP_SEARCH, 32'h5a5a_5a5b);
      wait_drained();

      run_phase(110, MODE_FILL);
      wait_drained();

      send_idle_pct = 73;
      recv_idle_pct = 18;
      run_phase(125, MODE_DRAIN);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(125, MODE_FILL);
      wait_drained();

      // let any stray item show up before the verdict
      repeat (80) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ files.f @@
sv/lss_pkg.sv
sv/lss_ram.sv
sv/lifo_stack_with_search_top.sv
verif/lss_stack_checker.sv
verif/tb_lifo_stack_with_search_top.sv
